>>> rtl/gcm_pkg.sv
package gcm_pkg;

	localparam logic [1:0] CMD_CLEAR  = 2'd0;
	localparam logic [1:0] CMD_LOAD   = 2'd1;
	localparam logic [1:0] CMD_CHANGE = 2'd2;

	localparam logic [1:0] ST_COIN  = 2'd0;
	localparam logic [1:0] ST_EXACT = 2'd1;
	localparam logic [1:0] ST_NONE  = 2'd2;
	localparam logic [1:0] ST_LIMIT = 2'd3;

	localparam int unsigned VAL_W = 16;

	typedef struct packed {
		logic [VAL_W-1:0] coin;
		logic [1:0]       status;
		logic             last;
	} rsp_t;

endpackage

>>> rtl/gcm_table.sv
module gcm_table #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned ADDR_W = 4
) (
	input  logic                           clk,
	input  logic                           we,
	input  logic [ADDR_W-1:0]              waddr,
	input  logic [gcm_pkg::VAL_W-1:0]      wdata,
	input  logic                           re,
	input  logic [ADDR_W-1:0]              raddr,
	output logic [gcm_pkg::VAL_W-1:0]      rdata
);

	logic [gcm_pkg::VAL_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/gcm_out.sv
module gcm_out (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  gcm_pkg::rsp_t              item,
	output logic                       can_push,
	output logic                       rsp_valid,
	input  logic                       rsp_ready,
	output logic [gcm_pkg::VAL_W-1:0]  coin,
	output logic [1:0]                 status,
	output logic                       last
);

	logic          valid_q;
	gcm_pkg::rsp_t item_q;

	assign can_push  = !valid_q || rsp_ready;
	assign rsp_valid = valid_q;
	assign coin      = item_q.coin;
	assign status    = item_q.status;
	assign last      = item_q.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_push) begin
			valid_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (push && can_push) begin
			item_q <= item;
		end
	end

endmodule

>>> rtl/greedy_change_maker.sv
// Greedy change maker. Denominations are kept largest first in a synchronous
// table with one write and one read port; each table read is followed by a
// state that compares the read data. A clear, an unused command or a dropped
// load returns straight to idle. A load reads back from the table end, moving
// each stored entry smaller than the new value one place down, and writes the
// new value behind the first entry not smaller than it, or at the front. A
// change request with no positive target goes straight to the closing status.
// Any other change request walks the denominations from the largest, issues a
// coin each time one fits, and closes with exact, with none when the walk runs
// off the table end, or with limit at MAX_COINS coins; coins and status wait on
// rsp_ready. No new request is taken until the closing status has been handed
// to the output register, which holds one result while the next request starts.
module greedy_change_maker #(
	parameter int unsigned TABLE_DEPTH = 16,
	parameter int unsigned MAX_COINS = 63
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_ready,
	input  logic [1:0]                 command,
	input  logic [gcm_pkg::VAL_W-1:0]  denomination,
	input  logic [gcm_pkg::VAL_W-1:0]  price,
	input  logic [gcm_pkg::VAL_W-1:0]  money,
	output logic                       rsp_valid,
	input  logic                       rsp_ready,
	output logic [gcm_pkg::VAL_W-1:0]  coin,
	output logic [1:0]                 status,
	output logic                       last
);

	localparam int unsigned ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned COIN_W = $clog2(MAX_COINS + 1);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);
	localparam logic [COIN_W-1:0] MAX_C = COIN_W'(MAX_COINS);

	typedef enum logic [2:0] {
		S_IDLE,
		S_LD_RD,
		S_LD_WR,
		S_CH_RD,
		S_CH_CHK,
		S_END
	} state_t;

	state_t                     state_q;
	logic [CNT_W-1:0]           count_q;
	logic [CNT_W-1:0]           ptr_q;
	logic [COIN_W-1:0]          coins_q;
	logic [gcm_pkg::VAL_W-1:0]  val_q;
	logic [gcm_pkg::VAL_W-1:0]  remain_q;
	logic [1:0]                 end_st_q;

	logic                       mem_we;
	logic [ADDR_W-1:0]          mem_waddr;
	logic [gcm_pkg::VAL_W-1:0]  mem_wdata;
	logic                       mem_re;
	logic [ADDR_W-1:0]          mem_raddr;
	logic [gcm_pkg::VAL_W-1:0]  mem_rdata;

	logic                       push;
	gcm_pkg::rsp_t              item;
	logic                       can_push;
	logic                       req_acc;
	logic [CNT_W-1:0]           ptr_m1;

	assign req_ready = (state_q == S_IDLE);
	assign req_acc   = req_valid && req_ready;
	assign ptr_m1    = ptr_q - CNT_W'(1);

	gcm_table #(
		.DEPTH  (TABLE_DEPTH),
		.ADDR_W (ADDR_W)
	) u_table (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	gcm_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.item      (item),
		.can_push  (can_push),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.coin      (coin),
		.status    (status),
		.last      (last)
	);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = ptr_q[ADDR_W-1:0];
		mem_wdata = val_q;
		mem_re    = 1'b0;
		mem_raddr = ptr_m1[ADDR_W-1:0];
		push      = 1'b0;
		item      = '{coin: mem_rdata, status: gcm_pkg::ST_COIN, last: 1'b0};
		case (state_q)
			S_LD_RD: begin
				if (ptr_q == '0) begin
					mem_we = 1'b1;
				end else begin
					mem_re = 1'b1;
				end
			end
			S_LD_WR: begin
				mem_we = 1'b1;
				if (mem_rdata < val_q) begin
					mem_wdata = mem_rdata;
				end
			end
			S_CH_RD: begin
				mem_raddr = ptr_q[ADDR_W-1:0];
				mem_re    = (ptr_q != count_q);
			end
			S_CH_CHK: begin
				push = (mem_rdata <= remain_q) && (coins_q != MAX_C);
			end
			S_END: begin
				push = 1'b1;
				item = '{coin: '0, status: end_st_q, last: 1'b1};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			ptr_q    <= '0;
			coins_q  <= '0;
			val_q    <= '0;
			remain_q <= '0;
			end_st_q <= gcm_pkg::ST_NONE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_acc) begin
						case (command)
							gcm_pkg::CMD_CLEAR: begin
								count_q <= '0;
							end
							gcm_pkg::CMD_LOAD: begin
								if (denomination != '0 && count_q < DEPTH_C) begin
									val_q   <= denomination;
									ptr_q   <= count_q;
									state_q <= S_LD_RD;
								end
							end
							gcm_pkg::CMD_CHANGE: begin
								if (money <= price) begin
									end_st_q <= gcm_pkg::ST_NONE;
									state_q  <= S_END;
								end else begin
									remain_q <= money - price;
									ptr_q    <= '0;
									coins_q  <= '0;
									state_q  <= S_CH_RD;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_LD_RD: begin
					if (ptr_q == '0) begin
						count_q <= count_q + CNT_W'(1);
						state_q <= S_IDLE;
					end else begin
						state_q <= S_LD_WR;
					end
				end
				S_LD_WR: begin
					if (mem_rdata >= val_q) begin
						count_q <= count_q + CNT_W'(1);
						state_q <= S_IDLE;
					end else begin
						ptr_q   <= ptr_m1;
						state_q <= S_LD_RD;
					end
				end
				S_CH_RD: begin
					if (ptr_q == count_q) begin
						end_st_q <= gcm_pkg::ST_NONE;
						state_q  <= S_END;
					end else begin
						state_q <= S_CH_CHK;
					end
				end
				S_CH_CHK: begin
					if (mem_rdata > remain_q) begin
						ptr_q   <= ptr_q + CNT_W'(1);
						state_q <= S_CH_RD;
					end else if (coins_q == MAX_C) begin
						end_st_q <= gcm_pkg::ST_LIMIT;
						state_q  <= S_END;
					end else if (can_push) begin
						coins_q  <= coins_q + COIN_W'(1);
						remain_q <= remain_q - mem_rdata;
						if (remain_q == mem_rdata) begin
							end_st_q <= gcm_pkg::ST_EXACT;
							state_q  <= S_END;
						end
					end
				end
				S_END: begin
					if (can_push) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("table count beyond depth");

	a_coins_bound: assert property (@(posedge clk) disable iff (!arst_n)
		coins_q <= MAX_C)
		else $error("coin count beyond limit");

	a_check_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CH_CHK |-> ptr_q < count_q)
		else $error("change walk past table end");

	a_coin_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		push && can_push && !item.last |-> item.coin != '0 && item.coin <= remain_q)
		else $error("coin zero or overshoots remainder");

	a_load_grows: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LD_WR && mem_rdata >= val_q |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("load did not grow table");

endmodule
